// ===== hw/rtl/ppdi_pkg.sv =====
// ppdi_pkg: shared types, codes and constants of the per-port datagram inbox
// used by ppdi_ctrl, ppdi_dpath and per_port_datagram_inbox_top
// no dependencies
package ppdi_pkg;

   // default sizes
   localparam int PORT_ENTRIES_DEF = 16;
   localparam int QUEUE_DEPTH_DEF  = 64;

   // register reset values and fixed constants
   localparam logic [15:0] EPH_FIRST_RST = 16'd49152;
   localparam logic [15:0] EPH_LAST_RST  = 16'd65535;
   localparam logic [31:0] ADDR_BASE     = 32'h0A00_0000;
   localparam logic [7:0]  MAX_SLOT      = 8'd254;
   localparam logic [7:0]  REF_MAX       = 8'hFF;
   localparam logic [16:0] HDR_BYTES     = 17'd4;
   localparam logic [16:0] MAX_FRAME     = 17'd65539;

   // register indexes
   localparam logic CSR_EPH_FIRST = 1'b0;
   localparam logic CSR_EPH_LAST  = 1'b1;

   // actions
   localparam logic [2:0] ACT_BIND   = 3'd0;
   localparam logic [2:0] ACT_UNBIND = 3'd1;
   localparam logic [2:0] ACT_PUSH   = 3'd2;
   localparam logic [2:0] ACT_POP    = 3'd3;
   localparam logic [2:0] ACT_PURGE  = 3'd4;

   // result status codes
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_SHORT   = 3'd1;
   localparam logic [2:0] ST_UNBOUND = 3'd2;
   localparam logic [2:0] ST_FULL    = 3'd3;
   localparam logic [2:0] ST_BADSLOT = 3'd4;
   localparam logic [2:0] ST_EMPTY   = 3'd5;
   localparam logic [2:0] ST_NO_FREE = 3'd6;

   // datapath operations
   localparam logic [4:0] OP_NONE        = 5'd0;
   localparam logic [4:0] OP_LOAD        = 5'd1;
   localparam logic [4:0] OP_SCAN_INIT   = 5'd2;
   localparam logic [4:0] OP_SCAN_CAND   = 5'd3;
   localparam logic [4:0] OP_SCAN_STEP   = 5'd4;
   localparam logic [4:0] OP_CAND_NEXT   = 5'd5;
   localparam logic [4:0] OP_BIND        = 5'd6;
   localparam logic [4:0] OP_UNBIND      = 5'd7;
   localparam logic [4:0] OP_PUSH        = 5'd8;
   localparam logic [4:0] OP_POP_RD      = 5'd9;
   localparam logic [4:0] OP_POP         = 5'd10;
   localparam logic [4:0] OP_PURGE_INIT  = 5'd11;
   localparam logic [4:0] OP_PURGE_ENTRY = 5'd12;
   localparam logic [4:0] OP_PURGE_SKIP  = 5'd13;
   localparam logic [4:0] OP_PURGE_RD    = 5'd14;
   localparam logic [4:0] OP_PURGE_WR    = 5'd15;
   localparam logic [4:0] OP_PURGE_NEXT  = 5'd16;
   localparam logic [4:0] OP_REPLY       = 5'd17;

   // one stored datagram
   typedef struct packed {
      logic [7:0]  slot;
      logic [15:0] sport;
      logic [15:0] len;
      logic [15:0] handle;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic [4:0] op;
      logic [2:0] code;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [2:0] action;
      logic       port_zero;
      logic       len_bad;
      logic       slot_bad;
      logic       hit;
      logic       scan_done;
      logic       free;
      logic       full;
      logic       empty;
      logic       cand_over;
      logic       n_over;
      logic       pg_done;
      logic       pg_bound;
      logic       pg_more;
   } stat_type;

endpackage

// ===== hw/rtl/ppdi_ctrl.sv =====
// ppdi_ctrl: sequencer of the datagram inbox, at most one datapath operation per cycle
// depends on ppdi_pkg
module ppdi_ctrl
   import ppdi_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DECODE = 4'd1;
   localparam logic [3:0] S_EPH    = 4'd2;
   localparam logic [3:0] S_SCAN   = 4'd3;
   localparam logic [3:0] S_POP    = 4'd4;
   localparam logic [3:0] S_PG_ENT = 4'd5;
   localparam logic [3:0] S_PG_RD  = 4'd6;
   localparam logic [3:0] S_PG_WR  = 4'd7;
   localparam logic [3:0] S_REPLY  = 4'd8;

   logic [3:0] state_ff, state_in;
   logic [2:0] code_ff, code_in;

   assign busy = (state_ff != S_IDLE);

   // next state and command
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      cmd.op   = OP_NONE;
      cmd.code = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.op   = OP_LOAD;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            code_in = ST_OK;
            case (stat.action)
               ACT_BIND: begin
                  if (stat.port_zero) begin
                     state_in = S_EPH;
                  end else begin
                     cmd.op   = OP_SCAN_INIT;
                     state_in = S_SCAN;
                  end
               end
               ACT_PUSH: begin
                  if (stat.len_bad) begin
                     code_in  = ST_SHORT;
                     state_in = S_REPLY;
                  end else begin
                     cmd.op   = OP_SCAN_INIT;
                     state_in = S_SCAN;
                  end
               end
               ACT_PURGE: begin
                  if (stat.slot_bad) begin
                     code_in  = ST_BADSLOT;
                     cmd.op   = OP_SCAN_INIT;
                     state_in = S_SCAN;
                  end else begin
                     cmd.op   = OP_PURGE_INIT;
                     state_in = S_PG_ENT;
                  end
               end
               default: begin
                  cmd.op   = OP_SCAN_INIT;
                  state_in = S_SCAN;
               end
            endcase
         end
         // next ephemeral candidate
         S_EPH: begin
            if (stat.n_over || stat.cand_over) begin
               code_in  = ST_NO_FREE;
               state_in = S_REPLY;
            end else begin
               cmd.op   = OP_SCAN_CAND;
               state_in = S_SCAN;
            end
         end
         // walk the port table, then act on the result
         S_SCAN: begin
            if (!stat.scan_done) begin
               cmd.op = OP_SCAN_STEP;
            end else begin
               state_in = S_REPLY;
               case (stat.action)
                  ACT_BIND: begin
                     if (stat.port_zero && stat.hit) begin
                        cmd.op   = OP_CAND_NEXT;
                        state_in = S_EPH;
                     end else if (stat.hit || stat.free) begin
                        cmd.op = OP_BIND;
                     end else begin
                        code_in = ST_NO_FREE;
                     end
                  end
                  ACT_UNBIND: begin
                     if (stat.hit) cmd.op = OP_UNBIND;
                     else code_in = ST_UNBOUND;
                  end
                  ACT_PUSH: begin
                     if (!stat.hit) code_in = ST_UNBOUND;
                     else if (stat.full) code_in = ST_FULL;
                     else if (stat.slot_bad) code_in = ST_BADSLOT;
                     else cmd.op = OP_PUSH;
                  end
                  ACT_POP: begin
                     if (!stat.hit) begin
                        code_in = ST_UNBOUND;
                     end else if (stat.empty) begin
                        code_in = ST_EMPTY;
                     end else begin
                        cmd.op   = OP_POP_RD;
                        state_in = S_POP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_POP: begin
            cmd.op   = OP_POP;
            state_in = S_REPLY;
         end
         // purge: one table entry at a time
         S_PG_ENT: begin
            if (stat.pg_done) begin
               cmd.op   = OP_SCAN_INIT;
               state_in = S_SCAN;
            end else if (!stat.pg_bound) begin
               cmd.op = OP_PURGE_SKIP;
            end else begin
               cmd.op   = OP_PURGE_ENTRY;
               state_in = S_PG_RD;
            end
         end
         S_PG_RD: begin
            if (stat.pg_more) begin
               cmd.op   = OP_PURGE_RD;
               state_in = S_PG_WR;
            end else begin
               cmd.op   = OP_PURGE_NEXT;
               state_in = S_PG_ENT;
            end
         end
         S_PG_WR: begin
            cmd.op   = OP_PURGE_WR;
            state_in = S_PG_RD;
         end
         S_REPLY: begin
            cmd.op   = OP_REPLY;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

// ===== hw/rtl/ppdi_dpath.sv =====
// ppdi_dpath: port table, reference counts, queue pointers and datagram memory
// depends on ppdi_pkg; sequenced by ppdi_ctrl
module ppdi_dpath
   import ppdi_pkg::*;
#(
   parameter int PORT_ENTRIES = PORT_ENTRIES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic [2:0]         req_action,
   input  logic [15:0]        req_port,
   input  logic signed [8:0]  req_source_slot,
   input  logic [31:0]        req_frame_header,
   input  logic [16:0]        req_frame_length,
   input  logic [15:0]        req_payload_handle,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_bound_port,
   output logic [31:0]        rsp_source_address,
   output logic [15:0]        rsp_source_port,
   output logic [15:0]        rsp_payload_length,
   output logic [15:0]        rsp_payload_ref,
   output logic [6:0]         rsp_queue_count
);

   localparam int EW = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int NW = $clog2(PORT_ENTRIES + 2);

   // (a + b) mod depth for a sum a + b below twice the depth
   function automatic logic [PW-1:0] wrap(input logic [CW:0] s);
      logic [CW:0] d;
      d = (CW+1)'(QUEUE_DEPTH);
      if (s >= d) return PW'(s - d);
      else return PW'(s);
   endfunction

   // config registers
   logic [15:0] eph_first_ff, eph_last_ff;

   // latched request
   logic [2:0]  act_ff;
   logic [15:0] port_ff, hdl_ff;
   logic [8:0]  slot_ff;
   logic [31:0] hdr_ff;
   logic [16:0] flen_ff;

   // scan state
   logic [15:0]   tgt_ff;
   logic [EW-1:0] idx_ff, hit_idx_ff, free_idx_ff;
   logic          end_ff, hit_ff, free_ff;
   logic [16:0]   cand_ff;
   logic [NW-1:0] n_ff;

   // port table and queue pointers
   logic [15:0]   tbl_ff  [PORT_ENTRIES];
   logic [7:0]    ref_ff  [PORT_ENTRIES];
   logic [PW-1:0] head_ff [PORT_ENTRIES];
   logic [CW-1:0] fill_ff [PORT_ENTRIES];

   // purge walk
   logic [EW:0]   pe_ff;
   logic [PW-1:0] ph_ff;
   logic [CW-1:0] pf_ff, k_ff, kept_ff;

   // datagram memory
   entry_type queue_mem [PORT_ENTRIES][QUEUE_DEPTH];
   entry_type rd_ff;
   logic          mem_we, mem_re;
   logic [EW-1:0] mem_we_e, mem_re_e;
   logic [PW-1:0] mem_we_p, mem_re_p;
   entry_type     mem_wd;

   logic [EW-1:0] pe_idx;
   logic [15:0]   key;
   logic          slot_bad, scan_match, scan_free;
   logic [CW-1:0] hit_fill;
   logic [31:0]   cnt_w;
   logic          rep_ok;

   assign pe_idx     = pe_ff[EW-1:0];
   assign key        = (act_ff == ACT_PUSH) ? hdr_ff[31:16] : port_ff;
   assign slot_bad   = slot_ff[8] || (slot_ff[7:0] > MAX_SLOT);
   assign scan_match = (ref_ff[idx_ff] != 8'd0) && (tbl_ff[idx_ff] == tgt_ff);
   assign scan_free  = (ref_ff[idx_ff] == 8'd0);
   assign hit_fill   = fill_ff[hit_idx_ff];
   assign cnt_w      = ((hit_ff && cmd.code != ST_NO_FREE) ? 32'(hit_fill) : 32'd0);
   assign rep_ok     = (cmd.code == ST_OK);

   // status back to the controller
   always_comb begin
      stat.action    = act_ff;
      stat.port_zero = (port_ff == 16'd0);
      stat.len_bad   = (flen_ff < HDR_BYTES) || (flen_ff > MAX_FRAME);
      stat.slot_bad  = slot_bad;
      stat.hit       = hit_ff;
      stat.scan_done = hit_ff || end_ff;
      stat.free      = free_ff;
      stat.full      = (hit_fill == CW'(QUEUE_DEPTH));
      stat.empty     = (hit_fill == '0);
      stat.cand_over = (cand_ff > {1'b0, eph_last_ff});
      stat.n_over    = (n_ff == NW'(PORT_ENTRIES + 1));
      stat.pg_done   = (pe_ff == (EW+1)'(PORT_ENTRIES));
      stat.pg_bound  = (ref_ff[pe_idx] != 8'd0);
      stat.pg_more   = (k_ff != pf_ff);
   end

   // memory port selection
   always_comb begin
      mem_we   = 1'b0;
      mem_we_e = hit_idx_ff;
      mem_we_p = wrap((CW+1)'(head_ff[hit_idx_ff]) + (CW+1)'(hit_fill));
      mem_wd.slot   = slot_ff[7:0];
      mem_wd.sport  = hdr_ff[15:0];
      mem_wd.len    = 16'(flen_ff - HDR_BYTES);
      mem_wd.handle = hdl_ff;
      mem_re   = 1'b0;
      mem_re_e = hit_idx_ff;
      mem_re_p = head_ff[hit_idx_ff];
      case (cmd.op)
         OP_PUSH: mem_we = 1'b1;
         OP_POP_RD: mem_re = 1'b1;
         OP_PURGE_RD: begin
            mem_re   = 1'b1;
            mem_re_e = pe_idx;
            mem_re_p = wrap((CW+1)'(ph_ff) + (CW+1)'(k_ff));
         end
         OP_PURGE_WR: begin
            mem_we   = (rd_ff.slot != slot_ff[7:0]);
            mem_we_e = pe_idx;
            mem_we_p = wrap((CW+1)'(ph_ff) + (CW+1)'(kept_ff));
            mem_wd   = rd_ff;
         end
         default: begin
         end
      endcase
   end

   // datagram memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) queue_mem[mem_we_e][mem_we_p] <= mem_wd;
      if (mem_re) rd_ff <= queue_mem[mem_re_e][mem_re_p];
   end

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         eph_first_ff <= EPH_FIRST_RST;
         eph_last_ff  <= EPH_LAST_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_EPH_FIRST: eph_first_ff <= csr_data;
            CSR_EPH_LAST:  eph_last_ff  <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // operation execution
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PORT_ENTRIES; i++) begin
            ref_ff[i]  <= 8'd0;
            head_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
         hit_ff    <= 1'b0;
         end_ff    <= 1'b0;
         free_ff   <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         case (cmd.op)
            OP_LOAD: begin
               act_ff  <= req_action;
               port_ff <= req_port;
               slot_ff <= req_source_slot;
               hdr_ff  <= req_frame_header;
               flen_ff <= req_frame_length;
               hdl_ff  <= req_payload_handle;
               hit_ff  <= 1'b0;
               cand_ff <= (eph_first_ff == 16'd0) ? 17'd1 : {1'b0, eph_first_ff};
               n_ff    <= '0;
            end
            OP_SCAN_INIT, OP_SCAN_CAND: begin
               tgt_ff  <= (cmd.op == OP_SCAN_CAND) ? cand_ff[15:0] : key;
               idx_ff  <= '0;
               hit_ff  <= 1'b0;
               end_ff  <= 1'b0;
               free_ff <= 1'b0;
            end
            OP_SCAN_STEP: begin
               if (scan_match) begin
                  hit_ff     <= 1'b1;
                  hit_idx_ff <= idx_ff;
               end
               if (scan_free && !free_ff) begin
                  free_ff     <= 1'b1;
                  free_idx_ff <= idx_ff;
               end
               if (idx_ff == EW'(PORT_ENTRIES - 1)) end_ff <= 1'b1;
               else idx_ff <= idx_ff + 1'b1;
            end
            OP_CAND_NEXT: begin
               cand_ff <= cand_ff + 17'd1;
               n_ff    <= n_ff + 1'b1;
            end
            OP_BIND: begin
               if (hit_ff) begin
                  if (ref_ff[hit_idx_ff] != REF_MAX)
                     ref_ff[hit_idx_ff] <= ref_ff[hit_idx_ff] + 8'd1;
               end else begin
                  tbl_ff[free_idx_ff]  <= tgt_ff;
                  ref_ff[free_idx_ff]  <= 8'd1;
                  head_ff[free_idx_ff] <= '0;
                  fill_ff[free_idx_ff] <= '0;
                  hit_idx_ff <= free_idx_ff;
                  hit_ff     <= 1'b1;
               end
            end
            OP_UNBIND: begin
               ref_ff[hit_idx_ff] <= ref_ff[hit_idx_ff] - 8'd1;
               if (ref_ff[hit_idx_ff] == 8'd1) begin
                  head_ff[hit_idx_ff] <= '0;
                  fill_ff[hit_idx_ff] <= '0;
               end
            end
            OP_PUSH: fill_ff[hit_idx_ff] <= hit_fill + 1'b1;
            OP_POP: begin
               head_ff[hit_idx_ff] <= wrap((CW+1)'(head_ff[hit_idx_ff]) + (CW+1)'(1));
               fill_ff[hit_idx_ff] <= hit_fill - 1'b1;
            end
            OP_PURGE_INIT: pe_ff <= '0;
            OP_PURGE_ENTRY: begin
               ph_ff   <= head_ff[pe_idx];
               pf_ff   <= fill_ff[pe_idx];
               k_ff    <= '0;
               kept_ff <= '0;
            end
            OP_PURGE_SKIP: pe_ff <= pe_ff + 1'b1;
            OP_PURGE_WR: begin
               if (rd_ff.slot != slot_ff[7:0]) kept_ff <= kept_ff + 1'b1;
               k_ff <= k_ff + 1'b1;
            end
            OP_PURGE_NEXT: begin
               fill_ff[pe_idx] <= kept_ff;
               pe_ff <= pe_ff + 1'b1;
            end
            // result beat
            OP_REPLY: begin
               rsp_valid      <= 1'b1;
               rsp_status     <= cmd.code;
               rsp_bound_port <= (act_ff == ACT_BIND && rep_ok) ? tgt_ff : 16'd0;
               if (act_ff == ACT_POP && rep_ok) begin
                  rsp_source_address <= ADDR_BASE | (32'(rd_ff.slot) + 32'd1);
                  rsp_source_port    <= rd_ff.sport;
                  rsp_payload_length <= rd_ff.len;
                  rsp_payload_ref    <= rd_ff.handle;
               end else begin
                  rsp_source_address <= 32'd0;
                  rsp_source_port    <= 16'd0;
                  rsp_payload_length <= 16'd0;
                  rsp_payload_ref    <= 16'd0;
               end
               rsp_queue_count <= cnt_w[6:0];
            end
            default: begin
            end
         endcase
      end
   end

endmodule

// ===== hw/rtl/per_port_datagram_inbox_top.sv =====
// Per-port datagram inbox. A command is taken when start is high and busy is low;
// its one result beat appears later on the rsp_ ports for one cycle with rsp_valid
// high and cannot be held off. Time per command is set by the port table walk, one
// entry a cycle, that bind, unbind, push and pop make and that a hit ends early; a
// bind for port zero repeats the walk for each candidate tried, up to PORT_ENTRIES
// + 1 of them, and a source purge also visits every table entry, reads each stored
// datagram of each bound port and writes back the ones it keeps. The datagram memory
// has one read and one write port and needs no clearing after reset.
// depends on ppdi_pkg, ppdi_ctrl, ppdi_dpath
module per_port_datagram_inbox_top
   import ppdi_pkg::*;
#(
   parameter int PORT_ENTRIES = PORT_ENTRIES_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_action,
   input  logic [15:0]        req_port,
   input  logic signed [8:0]  req_source_slot,
   input  logic [31:0]        req_frame_header,
   input  logic [16:0]        req_frame_length,
   input  logic [15:0]        req_payload_handle,
   output logic               rsp_valid,
   output logic [2:0]         rsp_status,
   output logic [15:0]        rsp_bound_port,
   output logic [31:0]        rsp_source_address,
   output logic [15:0]        rsp_source_port,
   output logic [15:0]        rsp_payload_length,
   output logic [15:0]        rsp_payload_ref,
   output logic [6:0]         rsp_queue_count,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data
);

   cmd_type  cmd;
   stat_type stat;

   // sequencer
   ppdi_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // tables, queues and result register
   ppdi_dpath #(
      .PORT_ENTRIES (PORT_ENTRIES),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_action         (req_action),
      .req_port           (req_port),
      .req_source_slot    (req_source_slot),
      .req_frame_header   (req_frame_header),
      .req_frame_length   (req_frame_length),
      .req_payload_handle (req_payload_handle),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_bound_port     (rsp_bound_port),
      .rsp_source_address (rsp_source_address),
      .rsp_source_port    (rsp_source_port),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_ref    (rsp_payload_ref),
      .rsp_queue_count    (rsp_queue_count)
   );

`ifndef SYNTHESIS
   // a result beat only comes once the command is finished
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while busy");
   // an accepted command keeps the block busy
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("command not taken");
   // failed commands carry no bound port and no datagram
   a_fail_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |->
         (rsp_bound_port == 16'd0 && rsp_source_address == 32'd0))
      else $error("fields set on failure");
   // an empty queue reports a zero count
   a_empty_cnt: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_queue_count == 7'd0))
      else $error("empty queue with count");
`endif

endmodule

// ===== verif/per_port_datagram_inbox_checker.sv =====
// per_port_datagram_inbox_checker: watches the command, result and register ports of the
// datagram inbox, predicts each result beat and compares it field by field
// depends on ppdi_pkg
module per_port_datagram_inbox_checker
   import ppdi_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [2:0]         req_action,
   input  logic [15:0]        req_port,
   input  logic signed [8:0]  req_source_slot,
   input  logic [31:0]        req_frame_header,
   input  logic [16:0]        req_frame_length,
   input  logic [15:0]        req_payload_handle,
   input  logic               rsp_valid,
   input  logic [2:0]         rsp_status,
   input  logic [15:0]        rsp_bound_port,
   input  logic [31:0]        rsp_source_address,
   input  logic [15:0]        rsp_source_port,
   input  logic [15:0]        rsp_payload_length,
   input  logic [15:0]        rsp_payload_ref,
   input  logic [6:0]         rsp_queue_count,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [15:0]        csr_data,
   output int                 fail_count,
   output int                 pending
);

   localparam int PORT_N = PORT_ENTRIES_DEF;
   localparam int DEPTH  = QUEUE_DEPTH_DEF;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] bound_port;
      logic [31:0] source_address;
      logic [15:0] source_port;
      logic [15:0] payload_length;
      logic [15:0] payload_ref;
      logic [6:0]  queue_count;
   } reply_type;

   // shadow of the block state
   logic [15:0] eph_first, eph_last;
   logic [15:0] port_num [PORT_N];
   logic [7:0]  port_refs [PORT_N];
   entry_type   dgram_q [PORT_N][$];
   reply_type   replies_due [$];

   function automatic int lookup_port(int unsigned p);
      for (int i = 0; i < PORT_N; i++)
         if (port_refs[i] != 0 && port_num[i] == p) return i;
      return -1;
   endfunction

   function automatic int unsigned waiting_on(int unsigned p);
      int e;
      e = lookup_port(p);
      return (e < 0) ? 0 : dgram_q[e].size();
   endfunction

   // lowest unbound port of the ephemeral window, 0 if none
   function automatic int unsigned pick_free_port();
      int unsigned cand;
      cand = (eph_first == 16'd0) ? 32'd1 : 32'(eph_first);
      for (int n = 0; n <= PORT_N; n++) begin
         if (cand > eph_last) return 0;
         if (lookup_port(cand) < 0) return cand;
         cand++;
      end
      return 0;
   endfunction

   task automatic predict_reply(output reply_type r);
      int e;
      int sv;
      int unsigned p, dport;
      entry_type d;
      entry_type kept [$];
      r = '0;
      p = 32'(req_port);
      sv = int'(req_source_slot);
      case (req_action)
         ACT_BIND: begin
            if (p == 0) p = pick_free_port();
            if (p == 0) begin
               r.status = ST_NO_FREE;
            end else begin
               e = lookup_port(p);
               if (e >= 0) begin
                  if (port_refs[e] < REF_MAX) port_refs[e]++;
               end else begin
                  for (int i = 0; i < PORT_N; i++)
                     if (e < 0 && port_refs[i] == 0) e = i;
                  if (e >= 0) begin
                     port_num[e] = 16'(p);
                     port_refs[e] = 8'd1;
                     dgram_q[e].delete();
                  end
               end
               if (e < 0) r.status = ST_NO_FREE;
               else begin
                  r.bound_port = 16'(p);
                  r.queue_count = 7'(dgram_q[e].size());
               end
            end
         end
         ACT_UNBIND: begin
            e = lookup_port(p);
            if (e < 0) r.status = ST_UNBOUND;
            else begin
               port_refs[e]--;
               if (port_refs[e] == 0) dgram_q[e].delete();
               r.queue_count = (port_refs[e] != 0) ? 7'(dgram_q[e].size()) : 7'd0;
            end
         end
         ACT_PUSH: begin
            dport = 32'(req_frame_header[31:16]);
            if (req_frame_length < HDR_BYTES || req_frame_length > MAX_FRAME) begin
               r.status = ST_SHORT;
            end else begin
               e = lookup_port(dport);
               if (e < 0) r.status = ST_UNBOUND;
               else if (dgram_q[e].size() >= DEPTH) begin
                  r.status = ST_FULL;
                  r.queue_count = 7'(dgram_q[e].size());
               end else if (sv < 0 || sv > int'(MAX_SLOT)) begin
                  r.status = ST_BADSLOT;
                  r.queue_count = 7'(dgram_q[e].size());
               end else begin
                  d.slot   = sv[7:0];
                  d.sport  = req_frame_header[15:0];
                  d.len    = 16'(req_frame_length - HDR_BYTES);
                  d.handle = req_payload_handle;
                  dgram_q[e] = {dgram_q[e], d};
                  r.queue_count = 7'(dgram_q[e].size());
               end
            end
         end
         ACT_POP: begin
            e = lookup_port(p);
            if (e < 0) r.status = ST_UNBOUND;
            else if (dgram_q[e].size() == 0) r.status = ST_EMPTY;
            else begin
               d = dgram_q[e][0];
               dgram_q[e].delete(0);
               r.source_address = ADDR_BASE | (32'(d.slot) + 32'd1);
               r.source_port    = d.sport;
               r.payload_length = d.len;
               r.payload_ref    = d.handle;
               r.queue_count    = 7'(dgram_q[e].size());
            end
         end
         ACT_PURGE: begin
            if (sv < 0 || sv > int'(MAX_SLOT)) r.status = ST_BADSLOT;
            else begin
               // drop the slot's datagrams, keep the order of the rest
               for (int i = 0; i < PORT_N; i++) begin
                  if (port_refs[i] != 0) begin
                     kept.delete();
                     for (int k = 0; k < dgram_q[i].size(); k++)
                        if (dgram_q[i][k].slot != sv[7:0]) kept = {kept, dgram_q[i][k]};
                     dgram_q[i] = kept;
                  end
               end
            end
            r.queue_count = 7'(waiting_on(p));
         end
         default: r.queue_count = 7'(waiting_on(p));
      endcase
   endtask

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
      fail_count++;
   endtask

   task automatic check_beat();
      reply_type w;
      if (replies_due.size() == 0) begin
         report_mismatch("unexpected beat", 1, 0);
         return;
      end
      w = replies_due[0];
      replies_due.delete(0);
      if (rsp_status != w.status) report_mismatch("status", rsp_status, w.status);
      if (rsp_bound_port != w.bound_port)
         report_mismatch("bound_port", rsp_bound_port, w.bound_port);
      if (rsp_source_address != w.source_address)
         report_mismatch("source_address", rsp_source_address, w.source_address);
      if (rsp_source_port != w.source_port)
         report_mismatch("source_port", rsp_source_port, w.source_port);
      if (rsp_payload_length != w.payload_length)
         report_mismatch("payload_length", rsp_payload_length, w.payload_length);
      if (rsp_payload_ref != w.payload_ref)
         report_mismatch("payload_ref", rsp_payload_ref, w.payload_ref);
      if (rsp_queue_count != w.queue_count)
         report_mismatch("queue_count", rsp_queue_count, w.queue_count);
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   // result beats first, then register writes, then accepted commands
   always @(posedge clock) begin
      reply_type r;
      if (reset) begin
         eph_first = EPH_FIRST_RST;
         eph_last  = EPH_LAST_RST;
         for (int i = 0; i < PORT_N; i++) begin
            port_refs[i] = 8'd0;
            port_num[i] = 16'd0;
            dgram_q[i].delete();
         end
         replies_due.delete();
      end else begin
         if (rsp_valid) check_beat();
         if (csr_write) begin
            if (csr_index == CSR_EPH_FIRST) eph_first = csr_data;
            else eph_last = csr_data;
         end
         if (start && !busy) begin
            predict_reply(r);
            replies_due = {replies_due, r};
         end
      end
      pending = replies_due.size();
   end

endmodule

// ===== verif/per_port_datagram_inbox_top_tb.sv =====
// per_port_datagram_inbox_top_tb: drives commands and register writes into the datagram
// inbox in bursts, and gives the verdict from the checker's failure count
// depends on ppdi_pkg, per_port_datagram_inbox_top, per_port_datagram_inbox_checker
module per_port_datagram_inbox_top_tb;
   import ppdi_pkg::*;

   localparam int STALL_LIMIT = 40000;

   logic               clock, reset, start, busy;
   logic [2:0]         req_action;
   logic [15:0]        req_port;
   logic signed [8:0]  req_source_slot;
   logic [31:0]        req_frame_header;
   logic [16:0]        req_frame_length;
   logic [15:0]        req_payload_handle;
   logic               rsp_valid;
   logic [2:0]         rsp_status;
   logic [15:0]        rsp_bound_port;
   logic [31:0]        rsp_source_address;
   logic [15:0]        rsp_source_port;
   logic [15:0]        rsp_payload_length;
   logic [15:0]        rsp_payload_ref;
   logic [6:0]         rsp_queue_count;
   logic               csr_write;
   logic               csr_index;
   logic [15:0]        csr_data;
   int                 fail_count, pending, stall_cycles;

   // ports the random commands mostly aim at
   logic [15:0] port_pool [12] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd5, 16'd6, 16'd7,
                                   16'd8, 16'd100, 16'd49152, 16'd49153, 16'd65535};
   logic [16:0] len_edges [6] = '{17'd0, 17'd3, 17'd4, 17'd65539, 17'd65540, 17'h1FFFF};
   logic [15:0] win_first [6] = '{16'd49152, 16'd5, 16'd0, 16'd9, 16'd65535, 16'd1};
   logic [15:0] win_last  [6] = '{16'd65535, 16'd8, 16'd3, 16'd8, 16'd65535, 16'd65535};

   per_port_datagram_inbox_top dut (.*);

   per_port_datagram_inbox_checker scoreboard (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog on cycles with no beat either way
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_cmd(logic [2:0] act, logic [15:0] prt, logic [8:0] slot,
                           logic [31:0] hdr, logic [16:0] flen, logic [15:0] hdl);
      start = 1'b1;
      req_action = act;
      req_port = prt;
      req_source_slot = slot;
      req_frame_header = hdr;
      req_frame_length = flen;
      req_payload_handle = hdl;
      while (busy) @(negedge clock);
      @(negedge clock);
   endtask

   task automatic pause_sender(int cycles);
      start = 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   // register writes only once every result is back
   task automatic write_csr(logic idx, logic [15:0] val);
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = val;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   function automatic logic [15:0] pick_port();
      return ($urandom_range(0, 9) == 0) ? 16'($urandom) : port_pool[$urandom_range(0, 11)];
   endfunction

   task automatic random_cmd();
      int unsigned roll;
      logic [2:0]  act;
      logic [8:0]  slot;
      logic [16:0] flen;
      roll = $urandom_range(0, 99);
      if (roll < 14) act = ACT_BIND;
      else if (roll < 24) act = ACT_UNBIND;
      else if (roll < 62) act = ACT_PUSH;
      else if (roll < 88) act = ACT_POP;
      else if (roll < 94) act = ACT_PURGE;
      else act = 3'($urandom_range(5, 7));
      slot = ($urandom_range(0, 99) < 85) ? 9'($urandom_range(0, 5)) : 9'($urandom);
      roll = $urandom_range(0, 9);
      if (roll < 8) flen = 17'($urandom_range(4, 300));
      else if (roll == 8) flen = len_edges[$urandom_range(0, 5)];
      else flen = 17'($urandom);
      send_cmd(act, pick_port(), slot, {pick_port(), 16'($urandom)}, flen, 16'($urandom));
   endtask

   initial begin
      int burst;
      reset = 1'b1;
      start = 1'b0;
      req_action = ACT_BIND;
      req_port = '0;
      req_source_slot = '0;
      req_frame_header = '0;
      req_frame_length = '0;
      req_payload_handle = '0;
      csr_write = 1'b0;
      csr_index = CSR_EPH_FIRST;
      csr_data = '0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: bind paths, push checks, pops, purge, unbind, unknown actions
      send_cmd(ACT_BIND, 16'd0, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_BIND, 16'd49152, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_BIND, 16'd7, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_PUSH, 16'd0, 9'd0, 32'h0007_FFFF, 17'd4, 16'hFFFF);
      send_cmd(ACT_PUSH, 16'd0, 9'd1, 32'h0007_1234, 17'd3, 16'h0001);
      send_cmd(ACT_PUSH, 16'd0, 9'd254, 32'h0007_0000, 17'd65539, 16'h0000);
      send_cmd(ACT_PUSH, 16'd0, 9'd2, 32'h0007_0001, 17'd65540, 16'h1111);
      send_cmd(ACT_PUSH, 16'd0, 9'd2, 32'h0009_0001, 17'd10, 16'h2222);
      send_cmd(ACT_PUSH, 16'd0, 9'h1FF, 32'h0007_0002, 17'd10, 16'h3333);
      send_cmd(ACT_PUSH, 16'd0, 9'd255, 32'h0007_0003, 17'h1FFFF, 16'h4444);
      send_cmd(ACT_PUSH, 16'd0, 9'h100, 32'hC000_0003, 17'd20, 16'h5555);
      send_cmd(ACT_POP, 16'd7, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_PURGE, 16'd7, 9'd254, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_POP, 16'd7, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_POP, 16'd9, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_PURGE, 16'd49152, 9'h100, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_PURGE, 16'd49152, 9'd255, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_UNBIND, 16'd49152, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_UNBIND, 16'd49152, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(ACT_UNBIND, 16'd49152, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(3'd5, 16'd7, 9'd0, 32'd0, 17'd0, 16'd0);
      send_cmd(3'd7, 16'd65535, 9'd0, 32'd0, 17'd0, 16'd0);

      // saturate one reference count, then release it past zero
      repeat (258) send_cmd(ACT_BIND, 16'd100, 9'd0, 32'd0, 17'd0, 16'd0);
      repeat (257) send_cmd(ACT_UNBIND, 16'd100, 9'd0, 32'd0, 17'd0, 16'd0);

      // fill one queue past its depth, then drain it
      send_cmd(ACT_BIND, 16'd3, 9'd0, 32'd0, 17'd0, 16'd0);
      repeat (66) send_cmd(ACT_PUSH, 16'd0, 9'($urandom_range(0, 3)),
                           {16'd3, 16'($urandom)}, 17'($urandom_range(4, 999)),
                           16'($urandom));
      repeat (66) send_cmd(ACT_POP, 16'd3, 9'd0, 32'd0, 17'd0, 16'd0);

      // random traffic across several ephemeral windows
      for (int ph = 0; ph < 6; ph++) begin
         write_csr(CSR_EPH_FIRST, win_first[ph]);
         write_csr(CSR_EPH_LAST, win_last[ph]);
         for (int n = 0; n < 40; n += burst) begin
            burst = $urandom_range(1, 12);
            repeat (burst) random_cmd();
            if (ph != 2) pause_sender($urandom_range(0, 6));
         end
      end

      // drain
      start = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/ppdi_pkg.sv
hw/rtl/ppdi_ctrl.sv
hw/rtl/ppdi_dpath.sv
hw/rtl/per_port_datagram_inbox_top.sv
verif/per_port_datagram_inbox_checker.sv
verif/per_port_datagram_inbox_top_tb.sv
